// File: rtl/core/rast_pkg.sv
// ----------------------------------------------------------------------------
// rast_pkg
// Shared types and constants for the range-add / range-max segment tree.
// ----------------------------------------------------------------------------
package rast_pkg;

  // Field widths fixed by the interface
  localparam int LC_W   = 11;
  localparam int POS_W  = 16;
  localparam int DATA_W = 32;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_LEAF_COUNT  = 2'd0;
  localparam logic [1:0] REG_INDEX_BASE  = 2'd1;
  localparam logic [1:0] REG_UNSET_VALUE = 2'd2;

  // Register reset values
  localparam logic [LC_W-1:0]   LEAF_COUNT_RST  = 11'd1024;
  localparam logic [POS_W-1:0]  INDEX_BASE_RST  = 16'd0;
  localparam logic [DATA_W-1:0] UNSET_VALUE_RST = 32'h8000_0000;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SET,
    MODE_QUERY,
    MODE_CLEAR
  } mode_t;

  // Where a stack frame stands in its walk
  typedef enum logic [1:0] {
    PH_ENTER,
    PH_AFTER_L,
    PH_AFTER_R
  } phase_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_INPUT,
    LD_CLEAR
  } ld_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_SELF,
    RD_LEFT,
    RD_RIGHT
  } rd_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ADD,
    WR_SET,
    WR_CLR,
    WR_PULL
  } wr_t;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_ROOT,
    ST_PUSH_L,
    ST_PUSH_R,
    ST_POP
  } st_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_TMP_LOAD,
    ACC_TMP_CHOOSE,
    ACC_RET_LOAD,
    ACC_RET_ADD,
    ACC_SAVE_LEFT,
    ACC_COMBINE,
    ACC_V_SUB
  } acc_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_OK,
    EMIT_BAD
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    ld_t   ld;
    rd_t   rd;
    wr_t   wr;
    st_t   st;
    acc_t  acc;
    emit_t emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t  mode;
    phase_t ph;
    logic   sp_one;
    logic   is_leaf;
    logic   covered;
    logic   go_left;
    logic   go_right;
    logic   in_empty;
    logic   in_set_ok;
  } stat_t;

endpackage

// File: rtl/core/rast_regs.sv
// ----------------------------------------------------------------------------
// rast_regs
// APB-style configuration registers: leaf count, index base, unset value.
// ----------------------------------------------------------------------------
module rast_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [rast_pkg::LC_W-1:0]   leaf_count,
  output logic [rast_pkg::POS_W-1:0]  index_base,
  output logic [rast_pkg::DATA_W-1:0] unset_value,
  output logic        cfg_clr
);

  logic [rast_pkg::LC_W-1:0]   leaf_count_r;
  logic [rast_pkg::POS_W-1:0]  index_base_r;
  logic [rast_pkg::DATA_W-1:0] unset_value_r;
  logic [1:0]                  reg_idx;
  logic                        wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // a leaf count write requests a tree rebuild, taken only while the walk is idle
  assign cfg_clr = wr_en && (reg_idx == rast_pkg::REG_LEAF_COUNT);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r  <= rast_pkg::LEAF_COUNT_RST;
      index_base_r  <= rast_pkg::INDEX_BASE_RST;
      unset_value_r <= rast_pkg::UNSET_VALUE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        rast_pkg::REG_LEAF_COUNT:  leaf_count_r  <= pwdata[rast_pkg::LC_W-1:0];
        rast_pkg::REG_INDEX_BASE:  index_base_r  <= pwdata[rast_pkg::POS_W-1:0];
        rast_pkg::REG_UNSET_VALUE: unset_value_r <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      rast_pkg::REG_LEAF_COUNT:  prdata = {21'd0, leaf_count_r};
      rast_pkg::REG_INDEX_BASE:  prdata = {16'd0, index_base_r};
      rast_pkg::REG_UNSET_VALUE: prdata = unset_value_r;
      default:                   prdata = 32'd0;
    endcase
  end

  assign leaf_count  = leaf_count_r;
  assign index_base  = index_base_r;
  assign unset_value = unset_value_r;

endmodule

// File: rtl/core/rast_ctrl.sv
// ----------------------------------------------------------------------------
// rast_ctrl
// Sequencer for the tree walk: visits, node pulls, query folding, clears.
// ----------------------------------------------------------------------------
module rast_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_mode,
  input  logic                  cfg_clr,
  input  rast_pkg::stat_t       stat,
  output rast_pkg::cmd_t        cmd,
  output logic                  busy
);

  typedef enum logic [3:0] {
    S_CLR_START,
    S_IDLE,
    S_VISIT,
    S_TERM_WAIT,
    S_SET_WAIT,
    S_PULL_R,
    S_PULL_K,
    S_PULL_W,
    S_QADD,
    S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  rast_pkg::mode_t req_mode;
  logic            do_pop;
  logic            do_fin;

  assign req_mode = rast_pkg::mode_t'(in_mode);
  assign busy     = (state_r != S_IDLE) || cfg_clr;

  // next state and datapath commands
  always_comb begin
    cmd       = '{ld: rast_pkg::LD_NONE, rd: rast_pkg::RD_NONE, wr: rast_pkg::WR_NONE,
                  st: rast_pkg::ST_NONE, acc: rast_pkg::ACC_NONE,
                  emit: rast_pkg::EMIT_NONE};
    state_nxt = state_r;
    do_pop    = 1'b0;
    do_fin    = 1'b0;

    unique case (state_r)
      S_CLR_START: begin
        cmd.ld    = rast_pkg::LD_CLEAR;
        cmd.st    = rast_pkg::ST_ROOT;
        state_nxt = S_VISIT;
      end

      S_IDLE: begin
        if (cfg_clr) begin
          state_nxt = S_CLR_START;
        end else if (start) begin
          unique case (req_mode)
            rast_pkg::MODE_QUERY: begin
              if (stat.in_empty) begin
                cmd.emit = rast_pkg::EMIT_BAD;
              end else begin
                cmd.ld    = rast_pkg::LD_INPUT;
                cmd.st    = rast_pkg::ST_ROOT;
                state_nxt = S_VISIT;
              end
            end
            rast_pkg::MODE_ADD: begin
              if (!stat.in_empty) begin
                cmd.ld    = rast_pkg::LD_INPUT;
                cmd.st    = rast_pkg::ST_ROOT;
                state_nxt = S_VISIT;
              end
            end
            rast_pkg::MODE_SET: begin
              if (stat.in_set_ok) begin
                cmd.ld    = rast_pkg::LD_INPUT;
                cmd.st    = rast_pkg::ST_ROOT;
                state_nxt = S_VISIT;
              end
            end
            default: begin
              cmd.ld    = rast_pkg::LD_INPUT;
              cmd.st    = rast_pkg::ST_ROOT;
              state_nxt = S_VISIT;
            end
          endcase
        end
      end

      S_VISIT: begin
        unique case (stat.ph)
          rast_pkg::PH_ENTER: begin
            unique case (stat.mode) inside
              rast_pkg::MODE_ADD, rast_pkg::MODE_QUERY: begin
                if (stat.covered) begin
                  cmd.rd    = rast_pkg::RD_SELF;
                  state_nxt = S_TERM_WAIT;
                end else if (stat.go_left) begin
                  cmd.st = rast_pkg::ST_PUSH_L;
                end else begin
                  cmd.st = rast_pkg::ST_PUSH_R;
                end
              end
              rast_pkg::MODE_SET: begin
                if (stat.is_leaf) begin
                  cmd.wr = rast_pkg::WR_SET;
                  do_pop = 1'b1;
                end else begin
                  cmd.rd    = rast_pkg::RD_SELF;
                  state_nxt = S_SET_WAIT;
                end
              end
              default: begin
                cmd.wr = rast_pkg::WR_CLR;
                if (stat.is_leaf) do_pop = 1'b1;
                else cmd.st = rast_pkg::ST_PUSH_L;
              end
            endcase
          end
          rast_pkg::PH_AFTER_L: begin
            if (stat.mode == rast_pkg::MODE_QUERY) cmd.acc = rast_pkg::ACC_SAVE_LEFT;
            if (stat.go_right) cmd.st = rast_pkg::ST_PUSH_R;
            else do_fin = 1'b1;
          end
          rast_pkg::PH_AFTER_R: begin
            do_fin = 1'b1;
            if (stat.mode == rast_pkg::MODE_QUERY) cmd.acc = rast_pkg::ACC_COMBINE;
          end
          default: state_nxt = S_IDLE;
        endcase

        // children done: pull, fold or just leave
        if (do_fin) begin
          unique case (stat.mode) inside
            rast_pkg::MODE_ADD, rast_pkg::MODE_SET: begin
              cmd.rd    = rast_pkg::RD_LEFT;
              state_nxt = S_PULL_R;
            end
            rast_pkg::MODE_QUERY: begin
              cmd.rd    = rast_pkg::RD_SELF;
              state_nxt = S_QADD;
            end
            default: do_pop = 1'b1;
          endcase
        end
      end

      S_TERM_WAIT: begin
        if (stat.mode == rast_pkg::MODE_QUERY) cmd.acc = rast_pkg::ACC_RET_LOAD;
        else cmd.wr = rast_pkg::WR_ADD;
        do_pop = 1'b1;
      end

      S_SET_WAIT: begin
        cmd.acc   = rast_pkg::ACC_V_SUB;
        cmd.st    = stat.go_left ? rast_pkg::ST_PUSH_L : rast_pkg::ST_PUSH_R;
        state_nxt = S_VISIT;
      end

      S_PULL_R: begin
        cmd.rd    = rast_pkg::RD_RIGHT;
        cmd.acc   = rast_pkg::ACC_TMP_LOAD;
        state_nxt = S_PULL_K;
      end

      S_PULL_K: begin
        cmd.rd    = rast_pkg::RD_SELF;
        cmd.acc   = rast_pkg::ACC_TMP_CHOOSE;
        state_nxt = S_PULL_W;
      end

      S_PULL_W: begin
        cmd.wr = rast_pkg::WR_PULL;
        do_pop = 1'b1;
      end

      S_QADD: begin
        cmd.acc = rast_pkg::ACC_RET_ADD;
        do_pop  = 1'b1;
      end

      S_DONE: begin
        cmd.emit  = rast_pkg::EMIT_OK;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // leaving a frame: back to the parent, or the walk is over
    if (do_pop) begin
      cmd.st = rast_pkg::ST_POP;
      if (!stat.sp_one) state_nxt = S_VISIT;
      else if (stat.mode == rast_pkg::MODE_QUERY) state_nxt = S_DONE;
      else state_nxt = S_IDLE;
    end
  end

  // state register; reset starts with a clearing walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_START;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/rast_dp.sv
// ----------------------------------------------------------------------------
// rast_dp
// Datapath: node memory, walk stack, range clipping, node arithmetic, result.
// ----------------------------------------------------------------------------
module rast_dp #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rast_pkg::cmd_t                cmd,
  output rast_pkg::stat_t               stat,
  input  logic [1:0]                    in_mode,
  input  logic [15:0]                   in_first_index,
  input  logic [15:0]                   in_last_index,
  input  logic [31:0]                   in_operand_value,
  input  logic [rast_pkg::LC_W-1:0]     leaf_count,
  input  logic [rast_pkg::POS_W-1:0]    index_base,
  input  logic [rast_pkg::DATA_W-1:0]   unset_value,
  output logic                          out_valid,
  output logic [31:0]                   out_max_value,
  output logic [15:0]                   out_max_position,
  output logic                          out_status
);

  localparam int PW    = $clog2(MAX_LEAVES);
  localparam int KW    = PW + 1;
  localparam int DEPTH = 2 ** KW;
  localparam int SD    = PW + 1;
  localparam int SPW   = $clog2(SD + 1);
  localparam int SIW   = $clog2(SD);
  localparam int NW    = 64 + PW;

  // node word: {pending add, subtree max, max position}
  logic [NW-1:0]  node_mem_r [DEPTH];
  logic [NW-1:0]  rd_data_r;
  logic [31:0]    rd_pend, rd_max;
  logic [PW-1:0]  rd_pos;

  // walk stack
  logic [SPW-1:0]         sp_r;
  logic [KW-1:0]          fk_r  [SD];
  logic [PW-1:0]          flo_r [SD];
  logic [PW-1:0]          fhi_r [SD];
  rast_pkg::phase_t       fph_r [SD];
  logic                   fhl_r [SD];
  logic [31:0]            flv_r [SD];
  logic [PW-1:0]          flp_r [SD];
  logic [SIW-1:0]         tix, wix;

  // operation registers
  rast_pkg::mode_t        mode_r;
  logic [PW-1:0]          a_r, b_r;
  logic [31:0]            val_r;
  logic [31:0]            tmp_max_r, ret_val_r;
  logic [PW-1:0]          tmp_pos_r, ret_pos_r;

  // result registers
  logic                   out_valid_r;
  logic [31:0]            out_val_r;
  logic [15:0]            out_pos_r;
  logic                   out_status_r;

  // current frame
  logic [KW-1:0]          cur_k;
  logic [PW-1:0]          cur_lo, cur_hi, mid, mid_p1;
  logic [PW:0]            mid_sum;
  logic                   go_left, go_right;

  // range clipping
  logic [17:0]            lc_ext, max_ext, eff;
  logic signed [17:0]     top_s, a_s, b_s, lo_c, hi_c;

  logic                   wr_en, rd_en;
  logic [KW-1:0]          rd_addr;
  logic [NW-1:0]          wr_data;

  function automatic logic sgt(input logic [31:0] x, input logic [31:0] y);
    sgt = $signed(x) > $signed(y);
  endfunction

  // effective leaf count and top relative position
  assign lc_ext  = {7'd0, leaf_count};
  assign max_ext = 18'(MAX_LEAVES);
  assign eff     = (lc_ext == 18'd0) ? 18'd1 : ((lc_ext > max_ext) ? max_ext : lc_ext);
  assign top_s   = $signed(eff - 18'd1);

  // clip the request to the tree
  assign a_s  = $signed({2'b00, in_first_index}) - $signed({2'b00, index_base});
  assign b_s  = $signed({2'b00, in_last_index}) - $signed({2'b00, index_base});
  assign lo_c = a_s[17] ? 18'sd0 : a_s;
  assign hi_c = (b_s > top_s) ? top_s : b_s;

  // frame at the top of the stack
  assign tix     = SIW'(sp_r - SPW'(1));
  assign wix     = SIW'(sp_r);
  assign cur_k   = fk_r[tix];
  assign cur_lo  = flo_r[tix];
  assign cur_hi  = fhi_r[tix];
  assign mid_sum = {1'b0, cur_lo} + {1'b0, cur_hi};
  assign mid     = mid_sum[PW:1];
  assign mid_p1  = mid + PW'(1);

  always_comb begin
    case (mode_r)
      rast_pkg::MODE_SET: begin
        go_left  = a_r <= mid;
        go_right = !(a_r <= mid);
      end
      rast_pkg::MODE_CLEAR: begin
        go_left  = 1'b1;
        go_right = 1'b1;
      end
      default: begin
        go_left  = a_r <= mid;
        go_right = b_r > mid;
      end
    endcase
  end

  // status to the controller
  always_comb begin
    stat.mode      = mode_r;
    stat.ph        = fph_r[tix];
    stat.sp_one    = sp_r == SPW'(1);
    stat.is_leaf   = cur_lo == cur_hi;
    stat.covered   = (a_r <= cur_lo) && (cur_hi <= b_r);
    stat.go_left   = go_left;
    stat.go_right  = go_right;
    stat.in_empty  = lo_c > hi_c;
    stat.in_set_ok = !a_s[17] && (a_s <= top_s);
  end

  // stack pointer and operation mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      mode_r <= rast_pkg::MODE_CLEAR;
    end else begin
      case (cmd.st) inside
        rast_pkg::ST_ROOT:                     sp_r <= SPW'(1);
        rast_pkg::ST_PUSH_L, rast_pkg::ST_PUSH_R: sp_r <= sp_r + SPW'(1);
        rast_pkg::ST_POP:                      sp_r <= sp_r - SPW'(1);
        default: ;
      endcase
      case (cmd.ld)
        rast_pkg::LD_INPUT: mode_r <= rast_pkg::mode_t'(in_mode);
        rast_pkg::LD_CLEAR: mode_r <= rast_pkg::MODE_CLEAR;
        default: ;
      endcase
    end
  end

  // stack frames
  always_ff @(posedge clk) begin
    case (cmd.st)
      rast_pkg::ST_ROOT: begin
        fk_r[0]  <= KW'(1);
        flo_r[0] <= '0;
        fhi_r[0] <= top_s[PW-1:0];
        fph_r[0] <= rast_pkg::PH_ENTER;
        fhl_r[0] <= 1'b0;
      end
      rast_pkg::ST_PUSH_L: begin
        fph_r[tix] <= rast_pkg::PH_AFTER_L;
        fk_r[wix]  <= {cur_k[KW-2:0], 1'b0};
        flo_r[wix] <= cur_lo;
        fhi_r[wix] <= mid;
        fph_r[wix] <= rast_pkg::PH_ENTER;
        fhl_r[wix] <= 1'b0;
      end
      rast_pkg::ST_PUSH_R: begin
        fph_r[tix] <= rast_pkg::PH_AFTER_R;
        fk_r[wix]  <= {cur_k[KW-2:0], 1'b1};
        flo_r[wix] <= mid_p1;
        fhi_r[wix] <= cur_hi;
        fph_r[wix] <= rast_pkg::PH_ENTER;
        fhl_r[wix] <= 1'b0;
      end
      default: ;
    endcase
    // keep the left child's answer while the right one is walked
    if (cmd.acc == rast_pkg::ACC_SAVE_LEFT) begin
      flv_r[tix] <= ret_val_r;
      flp_r[tix] <= ret_pos_r;
      fhl_r[tix] <= 1'b1;
    end
  end

  // operands and accumulators
  always_ff @(posedge clk) begin
    if (cmd.ld == rast_pkg::LD_INPUT) begin
      a_r   <= lo_c[PW-1:0];
      b_r   <= hi_c[PW-1:0];
      val_r <= in_operand_value;
    end
    case (cmd.acc)
      rast_pkg::ACC_TMP_LOAD: begin
        tmp_max_r <= rd_max;
        tmp_pos_r <= rd_pos;
      end
      rast_pkg::ACC_TMP_CHOOSE: begin
        if (sgt(rd_max, tmp_max_r)) begin
          tmp_max_r <= rd_max;
          tmp_pos_r <= rd_pos;
        end
      end
      rast_pkg::ACC_RET_LOAD: begin
        ret_val_r <= rd_max;
        ret_pos_r <= rd_pos;
      end
      rast_pkg::ACC_RET_ADD: ret_val_r <= ret_val_r + rd_pend;
      rast_pkg::ACC_COMBINE: begin
        // ties stay with the left half
        if (fhl_r[tix] && !sgt(ret_val_r, flv_r[tix])) begin
          ret_val_r <= flv_r[tix];
          ret_pos_r <= flp_r[tix];
        end
      end
      rast_pkg::ACC_V_SUB: val_r <= val_r - rd_pend;
      default: ;
    endcase
  end

  // node memory access
  assign rd_pend = rd_data_r[NW-1 -: 32];
  assign rd_max  = rd_data_r[NW-33 -: 32];
  assign rd_pos  = rd_data_r[PW-1:0];
  assign rd_en   = cmd.rd != rast_pkg::RD_NONE;
  assign wr_en   = cmd.wr != rast_pkg::WR_NONE;

  always_comb begin
    case (cmd.rd)
      rast_pkg::RD_LEFT:  rd_addr = {cur_k[KW-2:0], 1'b0};
      rast_pkg::RD_RIGHT: rd_addr = {cur_k[KW-2:0], 1'b1};
      default:            rd_addr = cur_k;
    endcase
  end

  always_comb begin
    case (cmd.wr)
      rast_pkg::WR_ADD:  wr_data = {rd_pend + val_r, rd_max + val_r, rd_pos};
      rast_pkg::WR_SET:  wr_data = {val_r, val_r, cur_lo};
      rast_pkg::WR_CLR:  wr_data = {(cur_lo == cur_hi) ? unset_value : 32'd0,
                                    unset_value, cur_lo};
      rast_pkg::WR_PULL: wr_data = {rd_pend, rd_pend + tmp_max_r, tmp_pos_r};
      default:           wr_data = rd_data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) node_mem_r[cur_k] <= wr_data;
    if (rd_en) rd_data_r <= node_mem_r[rd_addr];
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit != rast_pkg::EMIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      rast_pkg::EMIT_OK: begin
        out_val_r    <= ret_val_r;
        out_pos_r    <= index_base + 16'(ret_pos_r);
        out_status_r <= 1'b0;
      end
      rast_pkg::EMIT_BAD: begin
        out_val_r    <= 32'd0;
        out_pos_r    <= 16'd0;
        out_status_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_max_value    = out_val_r;
  assign out_max_position = out_pos_r;
  assign out_status       = out_status_r;

  // stack never overflows on a push
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.st == rast_pkg::ST_PUSH_L || cmd.st == rast_pkg::ST_PUSH_R)
      |-> (sp_r != '0 && sp_r < SPW'(SD)))
    else $error("walk stack overflow");

  // never pop an empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.st == rast_pkg::ST_POP) |-> (sp_r != '0))
    else $error("walk stack underflow");

  // a leaf never gets children
  a_leaf_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.st == rast_pkg::ST_PUSH_L || cmd.st == rast_pkg::ST_PUSH_R)
      |-> (cur_lo != cur_hi))
    else $error("descent below a leaf");

  // every root push leaves exactly one frame
  a_root_one: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cmd.st == rast_pkg::ST_ROOT) |=> (sp_r == SPW'(1)))
    else $error("root push did not reset the stack");

endmodule

// File: rtl/core/range_add_max_segment_tree.sv
// ----------------------------------------------------------------------------
// range_add_max_segment_tree
// Range-add / range-max segment tree with leftmost argmax over up to
// MAX_LEAVES positions.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a transaction by holding start high with in_mode, in_first_index,
//   in_last_index and in_operand_value; it is taken at the edge where start
//   is high and busy is low. Modes: range add, point set, range max query,
//   clear. Only a query produces a result: out_valid pulses for one cycle
//   with out_max_value, out_max_position and out_status, and the receiver
//   must take it then. A query with an empty range is answered without
//   walking the tree. Other operations walk the tree one node visit at a
//   time through a single node memory; in an add or a set, each node on
//   the way back up is rebuilt from its two children. Clear (and a
//   leaf_count write) walks every node. After reset the block runs that
//   clearing walk with busy high; a leaf_count write rebuilds the tree
//   only when it lands while the walk sequencer is idle. Write
//   configuration only while busy is low.
// ----------------------------------------------------------------------------
module range_add_max_segment_tree #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_first_index,
  input  logic [15:0] in_last_index,
  input  logic [31:0] in_operand_value,
  // result channel
  output logic        out_valid,
  output logic [31:0] out_max_value,
  output logic [15:0] out_max_position,
  output logic        out_status,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rast_pkg::cmd_t                 cmd;
  rast_pkg::stat_t                stat;
  logic [rast_pkg::LC_W-1:0]      leaf_count;
  logic [rast_pkg::POS_W-1:0]     index_base;
  logic [rast_pkg::DATA_W-1:0]    unset_value;
  logic                           cfg_clr;

  // configuration registers
  rast_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .leaf_count  (leaf_count),
    .index_base  (index_base),
    .unset_value (unset_value),
    .cfg_clr     (cfg_clr)
  );

  // walk sequencer
  rast_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .cfg_clr (cfg_clr),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // node memory and arithmetic
  rast_dp #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_first_index   (in_first_index),
    .in_last_index    (in_last_index),
    .in_operand_value (in_operand_value),
    .leaf_count       (leaf_count),
    .index_base       (index_base),
    .unset_value      (unset_value),
    .out_valid        (out_valid),
    .out_max_value    (out_max_value),
    .out_max_position (out_max_position),
    .out_status       (out_status)
  );

endmodule
